[rtl/core/assert_macros.svh]
// Assertion macros shared by the button debouncer RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted (active low).
`define BDL_ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// Clocked assertion that is checked on every edge, reset included.
`define BDL_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`endif

[rtl/core/bdl_pkg.sv]
// Shared types and constants for the button debouncer with long-press detection.
// Used by the channel interfaces, the state machine and the top level.
`timescale 1ns / 1ps

package bdl_pkg;

    // Field widths.
    localparam int unsigned NOW_W     = 32;
    localparam int unsigned TIME_W    = 16;
    localparam int unsigned CFG_IDX_W = 1;

    // Request function codes.
    localparam logic FUNC_SERVICE = 1'b0;
    localparam logic FUNC_INIT    = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 1'b1;

    // Register reset values in milliseconds.
    localparam logic [TIME_W-1:0] DEBOUNCE_RESET   = 16'd20;
    localparam logic [TIME_W-1:0] LONG_PRESS_RESET = 16'd1000;

    // One button sample request.
    typedef struct packed {
        logic              func;
        logic              raw_pressed;
        logic [NOW_W-1:0]  now_ms;
    } t_req;

    // One result: three single-request edge flags and two levels.
    typedef struct packed {
        logic pressed_edge;
        logic long_hold_edge;
        logic released_edge;
        logic is_pressed;
        logic is_long_held;
    } t_rsp;

endpackage

[rtl/core/bdl_req_if.sv]
// Request channel of the button debouncer: valid/ready plus the sample payload.
// Depends on bdl_pkg for field widths.
`timescale 1ns / 1ps

interface bdl_req_if;
    import bdl_pkg::*;

    logic             valid;
    logic             ready;
    logic             func;
    logic             raw_pressed;
    logic [NOW_W-1:0] now_ms;

    modport source (output valid, func, raw_pressed, now_ms, input ready);
    modport sink   (input valid, func, raw_pressed, now_ms, output ready);
endinterface

[rtl/core/bdl_rsp_if.sv]
// Result channel of the button debouncer: valid/ready plus edge and level flags.
// Imports bdl_pkg, though no field here takes its width from it.
`timescale 1ns / 1ps

interface bdl_rsp_if;
    import bdl_pkg::*;

    logic valid;
    logic ready;
    logic pressed_edge;
    logic long_hold_edge;
    logic released_edge;
    logic is_pressed;
    logic is_long_held;

    modport source (output valid, pressed_edge, long_hold_edge, released_edge,
                    is_pressed, is_long_held, input ready);
    modport sink   (input valid, pressed_edge, long_hold_edge, released_edge,
                    is_pressed, is_long_held, output ready);
endinterface

[rtl/core/bdl_fsm.sv]
// Debounce and long-press state machine with its timestamp registers.
// Depends on bdl_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bdl_fsm (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  bdl_pkg::t_req                i_req,
    input  logic [bdl_pkg::TIME_W-1:0]   i_debounce_time,
    input  logic [bdl_pkg::TIME_W-1:0]   i_long_press_time,
    output bdl_pkg::t_rsp                o_rsp
);
    import bdl_pkg::*;

    typedef enum logic [2:0] {
        ST_RELEASED  = 3'd0,
        ST_DEB_PRESS = 3'd1,
        ST_PRESSED   = 3'd2,
        ST_LONG      = 3'd3,
        ST_DEB_REL_P = 3'd4,
        ST_DEB_REL_L = 3'd5
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [NOW_W-1:0] r_trans_start;
    logic [NOW_W-1:0] n_trans_start;
    logic [NOW_W-1:0] r_press_start;
    logic [NOW_W-1:0] n_press_start;
    logic             w_deb_reached;
    logic             w_long_reached;
    logic [NOW_W-1:0] w_trans_elapsed;
    logic [NOW_W-1:0] w_press_elapsed;

    // Elapsed times are modular differences, so the millisecond counter may wrap.
    assign w_trans_elapsed = i_req.now_ms - r_trans_start;
    assign w_press_elapsed = i_req.now_ms - r_press_start;
    assign w_deb_reached   = w_trans_elapsed >= NOW_W'(i_debounce_time);
    assign w_long_reached  = w_press_elapsed >= NOW_W'(i_long_press_time);

    // Next state, timestamps and edge flags for the current request.
    always_comb begin
        n_state       = r_state;
        n_trans_start = r_trans_start;
        n_press_start = r_press_start;
        o_rsp         = '0;
        if (i_req.func == FUNC_INIT) begin
            n_state       = i_req.raw_pressed ? ST_PRESSED : ST_RELEASED;
            n_trans_start = i_req.now_ms;
            n_press_start = i_req.now_ms;
        end else begin
            unique case (r_state) inside
                ST_DEB_PRESS: begin
                    if (!i_req.raw_pressed) begin
                        n_state = ST_RELEASED;
                    end else if (w_deb_reached) begin
                        n_state            = ST_PRESSED;
                        n_press_start      = i_req.now_ms;
                        o_rsp.pressed_edge = 1'b1;
                    end
                end
                ST_PRESSED: begin
                    if (!i_req.raw_pressed) begin
                        n_state       = ST_DEB_REL_P;
                        n_trans_start = i_req.now_ms;
                    end else if (w_long_reached) begin
                        n_state              = ST_LONG;
                        o_rsp.long_hold_edge = 1'b1;
                    end
                end
                ST_LONG: begin
                    if (!i_req.raw_pressed) begin
                        n_state       = ST_DEB_REL_L;
                        n_trans_start = i_req.now_ms;
                    end
                end
                ST_DEB_REL_P, ST_DEB_REL_L: begin
                    if (i_req.raw_pressed) begin
                        n_state = (r_state == ST_DEB_REL_P) ? ST_PRESSED : ST_LONG;
                    end else if (w_deb_reached) begin
                        n_state             = ST_RELEASED;
                        o_rsp.released_edge = 1'b1;
                    end
                end
                default: begin
                    // Released, and any code outside the machine, behave as released.
                    n_state = ST_RELEASED;
                    if (i_req.raw_pressed) begin
                        n_state       = ST_DEB_PRESS;
                        n_trans_start = i_req.now_ms;
                    end
                end
            endcase
        end
        o_rsp.is_pressed   = (n_state == ST_PRESSED) || (n_state == ST_LONG) ||
                             (n_state == ST_DEB_REL_P) || (n_state == ST_DEB_REL_L);
        o_rsp.is_long_held = (n_state == ST_LONG) || (n_state == ST_DEB_REL_L);
    end

    // State and timestamps advance once per processed request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_RELEASED;
            r_trans_start <= '0;
            r_press_start <= '0;
        end else if (i_step) begin
            r_state       <= n_state;
            r_trans_start <= n_trans_start;
            r_press_start <= n_press_start;
        end
    end

    // An accepted press restarts the long-press timer at the request's time.
    `BDL_ASSERT_RST(a_press_restarts_timer, i_clk, i_rst_n,
        i_step && o_rsp.pressed_edge |=>
            (r_state == ST_PRESSED) && (r_press_start == $past(i_req.now_ms)))
    // A long-hold edge always lands in the long-held state.
    `BDL_ASSERT_RST(a_long_edge_state, i_clk, i_rst_n,
        i_step && o_rsp.long_hold_edge |=> r_state == ST_LONG)
    // A release edge always returns the machine to released.
    `BDL_ASSERT_RST(a_release_edge_state, i_clk, i_rst_n,
        i_step && o_rsp.released_edge |=> r_state == ST_RELEASED)
endmodule

[rtl/core/button_debounce_long_press.sv]
// Button debouncer with long-press detection: sample in, one result out per sample.
// Top level. Depends on bdl_pkg, bdl_req_if, bdl_rsp_if, bdl_fsm and assert_macros.svh.
// Each request carries a raw active-high button level and a free-running millisecond
// time; every request produces exactly one result. The block takes one request per
// cycle while the output is not stalled: the request goes into an input register,
// the state machine and its two 32-bit elapsed-time compares update as it leaves
// that register, and the result lands in an output register. An initialize request
// forces the state to pressed or released from the raw level. Configuration writes
// (debounce time at index 0, long-press time at index 1, both in milliseconds) are
// taken at any edge with the write enable high and should only be made while no
// request is in flight.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module button_debounce_long_press (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    bdl_req_if.sink                        i_req,
    bdl_rsp_if.source                      o_rsp,
    input  logic                           i_cfg_we,
    input  logic [bdl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bdl_pkg::TIME_W-1:0]     i_cfg_data
);
    import bdl_pkg::*;

    t_req              r_req;
    logic              r_in_valid;
    t_rsp              r_rsp;
    t_rsp              w_rsp;
    logic              r_out_valid;
    logic [TIME_W-1:0] r_debounce_time;
    logic [TIME_W-1:0] r_long_press_time;
    logic              w_advance;
    logic              w_accept;

    // The working stage moves forward whenever the output register is free or draining.
    assign w_advance   = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || w_advance;
    assign w_accept    = i_req.valid && i_req.ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_time   <= DEBOUNCE_RESET;
            r_long_press_time <= LONG_PRESS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DEBOUNCE:   r_debounce_time   <= i_cfg_data;
                REG_LONG_PRESS: r_long_press_time <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req.func        <= i_req.func;
            r_req.raw_pressed <= i_req.raw_pressed;
            r_req.now_ms      <= i_req.now_ms;
        end
    end

    bdl_fsm u_fsm (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_step            (w_advance),
        .i_req             (r_req),
        .i_debounce_time   (r_debounce_time),
        .i_long_press_time (r_long_press_time),
        .o_rsp             (w_rsp)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_rsp <= w_rsp;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.pressed_edge   = r_rsp.pressed_edge;
    assign o_rsp.long_hold_edge = r_rsp.long_hold_edge;
    assign o_rsp.released_edge  = r_rsp.released_edge;
    assign o_rsp.is_pressed     = r_rsp.is_pressed;
    assign o_rsp.is_long_held   = r_rsp.is_long_held;

    // An accepted request always occupies the input register on the next cycle.
    `BDL_ASSERT_RST(a_accept_fills_stage, i_clk, i_rst_n, w_accept |=> r_in_valid)
    // A processed request always shows up as a pending result.
    `BDL_ASSERT_RST(a_advance_fills_out, i_clk, i_rst_n, w_advance |=> r_out_valid)
    // A request held behind a stalled result is neither lost nor processed.
    `BDL_ASSERT_RST(a_stall_keeps_req, i_clk, i_rst_n,
        r_in_valid && r_out_valid && !o_rsp.ready |-> !w_advance && !i_req.ready)
endmodule
